>>> src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define FQDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define FQDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fqds_pkg.sv
// types, constants and helper functions of the feedback scheduler
// used by every design and checker file of the block; no dependencies
package fqds_pkg;

    localparam int MAX_PROCS     = 16;
    localparam int TIME_BITS     = 16;
    localparam int IDX_W         = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int LVL_W         = 3;
    localparam int REM_W         = 16;
    localparam int SLICE_W       = 8;
    localparam int OUT_IDX_W     = 4;
    localparam int OUT_TIME_W    = 16;
    localparam int CELLS_PER_HOP = 4;
    localparam int NUM_HOPS      = (MAX_PROCS + CELLS_PER_HOP - 1) / CELLS_PER_HOP;
    localparam int HOP_CNT_W     = (NUM_HOPS > 1) ? $clog2(NUM_HOPS) : 1;

    localparam logic [LVL_W-1:0] LEVEL_CAP_RESET = 3'd7;
    localparam logic             FUNC_ARRIVE     = 1'b0;
    localparam logic             FUNC_TICK       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // token handed along the row of slot cells
    typedef struct packed {
        logic                 free_found;
        logic [IDX_W-1:0]     free_idx;
        logic                 oth_valid;
        logic                 best_found;
        logic [LVL_W-1:0]     best_eff;
        logic [LVL_W-1:0]     best_raw;
        logic [IDX_W-1:0]     best_idx;
        logic [REM_W-1:0]     best_rem;
        logic [TIME_BITS-1:0] best_arr;
        logic                 run_valid;
        logic [LVL_W-1:0]     run_lvl;
        logic [REM_W-1:0]     run_rem;
        logic [TIME_BITS-1:0] run_arr;
    } scan_t;

    // scheduler state seen by every cell
    typedef struct packed {
        logic [IDX_W-1:0] run_idx;
        logic             demote_pending;
        logic [LVL_W-1:0] level_cap;
    } sched_t;

    // write commands from the controller to the cells
    typedef struct packed {
        logic                 new_we;
        logic [IDX_W-1:0]     new_idx;
        logic [REM_W-1:0]     new_rem;
        logic [TIME_BITS-1:0] new_arr;
        logic                 upd_we;
        logic [IDX_W-1:0]     upd_idx;
        logic                 upd_valid;
        logic [REM_W-1:0]     upd_rem;
        logic                 lvl_we;
        logic [IDX_W-1:0]     lvl_idx;
        logic [LVL_W-1:0]     lvl_val;
    } cell_wr_t;

    // one level down, held at the cap
    function automatic logic [LVL_W-1:0] demote_level(input logic [LVL_W-1:0] lvl,
                                                      input logic [LVL_W-1:0] cap);
        logic [LVL_W:0] inc;
        inc = {1'b0, lvl} + {{LVL_W{1'b0}}, 1'b1};
        return (inc > {1'b0, cap}) ? cap : inc[LVL_W-1:0];
    endfunction

endpackage

>>> src/fqds_if.sv
// valid/ready channel interfaces of the feedback scheduler
// depends on fqds_pkg
interface fqds_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [fqds_pkg::REM_W-1:0]   work_units;

    modport source (output valid, output func, output work_units, input ready);
    modport sink   (input valid, input func, input work_units, output ready);
endinterface

interface fqds_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [fqds_pkg::OUT_IDX_W-1:0]    proc_index;
    logic                              idle;
    logic                              finished;
    logic [fqds_pkg::OUT_TIME_W-1:0]   finish_time;
    logic [fqds_pkg::OUT_TIME_W-1:0]   turnaround;
    logic                              rejected;

    modport source (output valid, output proc_index, output idle, output finished,
                    output finish_time, output turnaround, output rejected, input ready);
    modport sink   (input valid, input proc_index, input idle, input finished,
                    input finish_time, input turnaround, input rejected, output ready);
endinterface

>>> src/fqds_cell.sv
// one process slot: its stored state and its step of the selection chain
// depends on fqds_pkg
module fqds_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fqds_pkg::IDX_W-1:0]    cell_idx,
    input  fqds_pkg::sched_t              sched,
    input  fqds_pkg::cell_wr_t            wr,
    input  fqds_pkg::scan_t               scan_in,
    output fqds_pkg::scan_t               scan_out
);

    logic                             valid_reg;
    logic [fqds_pkg::REM_W-1:0]       rem_reg;
    logic [fqds_pkg::LVL_W-1:0]       lvl_reg;
    logic [fqds_pkg::TIME_BITS-1:0]   arr_reg;

    logic                             is_run;
    logic [fqds_pkg::LVL_W-1:0]       eff_lvl;
    logic                             hit_new;
    logic                             hit_upd;
    logic                             hit_lvl;

    assign hit_new = wr.new_we && (wr.new_idx == cell_idx);
    assign hit_upd = wr.upd_we && (wr.upd_idx == cell_idx);
    assign hit_lvl = wr.lvl_we && (wr.lvl_idx == cell_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hit_new)
        begin
            valid_reg <= 1'b1;
        end
        else if (hit_upd)
        begin
            valid_reg <= wr.upd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_new)
        begin
            rem_reg <= wr.new_rem;
            arr_reg <= wr.new_arr;
        end
        else if (hit_upd)
        begin
            rem_reg <= wr.upd_rem;
        end
        if (hit_new)
        begin
            lvl_reg <= '0;
        end
        else if (hit_lvl)
        begin
            lvl_reg <= wr.lvl_val;
        end
    end

    // running slot competes at its demoted level while a demotion waits
    assign is_run  = (cell_idx == sched.run_idx);
    assign eff_lvl = (is_run && sched.demote_pending)
                   ? fqds_pkg::demote_level(lvl_reg, sched.level_cap) : lvl_reg;

    always_comb
    begin
        scan_out = scan_in;
        if (!scan_in.free_found && !valid_reg)
        begin
            scan_out.free_found = 1'b1;
            scan_out.free_idx   = cell_idx;
        end
        if (valid_reg && !is_run)
        begin
            scan_out.oth_valid = 1'b1;
        end
        if (valid_reg && (!scan_in.best_found || (eff_lvl < scan_in.best_eff)))
        begin
            scan_out.best_found = 1'b1;
            scan_out.best_eff   = eff_lvl;
            scan_out.best_raw   = lvl_reg;
            scan_out.best_idx   = cell_idx;
            scan_out.best_rem   = rem_reg;
            scan_out.best_arr   = arr_reg;
        end
        if (is_run)
        begin
            scan_out.run_valid = valid_reg;
            scan_out.run_lvl   = lvl_reg;
            scan_out.run_rem   = rem_reg;
            scan_out.run_arr   = arr_reg;
        end
    end

endmodule

>>> src/fqds_ctrl.sv
// sequencer: takes items, waits for the cell chain, applies the decision
// depends on fqds_pkg and the channel interfaces in fqds_if
module fqds_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    fqds_req_if.sink                      req,
    fqds_rsp_if.source                    rsp,
    input  logic                          level_cap_we,
    input  logic [fqds_pkg::LVL_W-1:0]    level_cap_wdata,
    input  fqds_pkg::scan_t               scan,
    output fqds_pkg::sched_t              sched,
    output fqds_pkg::cell_wr_t            wr
);

    fqds_pkg::state_t                     state_reg, state_next;
    logic [fqds_pkg::HOP_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                 func_reg;
    logic [fqds_pkg::REM_W-1:0]           svc_reg;
    logic [fqds_pkg::TIME_BITS-1:0]       now_reg, now_next;
    logic [fqds_pkg::IDX_W-1:0]           run_reg, run_next;
    logic [fqds_pkg::SLICE_W-1:0]         slice_reg, slice_next;
    logic                                 dp_reg, dp_next;
    logic [fqds_pkg::LVL_W-1:0]           cap_reg;

    logic                                 out_valid_reg, out_valid_next;
    logic [fqds_pkg::OUT_IDX_W-1:0]       out_idx_reg, out_idx_next;
    logic                                 out_idle_reg, out_idle_next;
    logic                                 out_fin_reg, out_fin_next;
    logic [fqds_pkg::OUT_TIME_W-1:0]      out_ftime_reg, out_ftime_next;
    logic [fqds_pkg::OUT_TIME_W-1:0]      out_turn_reg, out_turn_next;
    logic                                 out_rej_reg, out_rej_next;

    logic                                 demote_apply;
    logic [fqds_pkg::LVL_W-1:0]           dem_lvl;
    logic                                 resume;
    logic [fqds_pkg::IDX_W-1:0]           pick;
    logic [fqds_pkg::REM_W-1:0]           pick_rem;
    logic [fqds_pkg::REM_W-1:0]           rem_dec;
    logic [fqds_pkg::TIME_BITS-1:0]       pick_arr;
    logic [fqds_pkg::LVL_W-1:0]           pick_lvl;
    logic [fqds_pkg::LVL_W-1:0]           quant_lvl;
    logic [fqds_pkg::SLICE_W-1:0]         slice_cur;
    logic [fqds_pkg::SLICE_W-1:0]         slice_dec;
    logic [fqds_pkg::TIME_BITS-1:0]       fin_t;
    logic                                 out_free;

    assign sched     = '{run_idx: run_reg, demote_pending: dp_reg, level_cap: cap_reg};
    assign req.ready = (state_reg == fqds_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.proc_index  = out_idx_reg;
    assign rsp.idle        = out_idle_reg;
    assign rsp.finished    = out_fin_reg;
    assign rsp.finish_time = out_ftime_reg;
    assign rsp.turnaround  = out_turn_reg;
    assign rsp.rejected    = out_rej_reg;

    // tick decision from the finished scan
    assign demote_apply = dp_reg && scan.run_valid && scan.oth_valid;
    assign dem_lvl      = fqds_pkg::demote_level(scan.run_lvl, cap_reg);
    assign resume       = (slice_reg != '0) && scan.run_valid;
    assign pick         = resume ? run_reg : scan.best_idx;
    assign pick_rem     = resume ? scan.run_rem : scan.best_rem;
    assign pick_arr     = resume ? scan.run_arr : scan.best_arr;
    assign pick_lvl     = (scan.best_idx == run_reg && demote_apply) ? dem_lvl : scan.best_raw;
    assign quant_lvl    = (pick_lvl > cap_reg) ? cap_reg : pick_lvl;
    assign slice_cur    = resume ? slice_reg
                                 : (fqds_pkg::SLICE_W'(1) << quant_lvl);
    assign slice_dec    = slice_cur - fqds_pkg::SLICE_W'(1);
    assign rem_dec      = (pick_rem == '0) ? '0 : pick_rem - fqds_pkg::REM_W'(1);
    assign fin_t        = now_reg + fqds_pkg::TIME_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqds_pkg::ST_IDLE;
            cnt_reg       <= '0;
            now_reg       <= '0;
            run_reg       <= '0;
            slice_reg     <= '0;
            dp_reg        <= 1'b0;
            cap_reg       <= fqds_pkg::LEVEL_CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            now_reg       <= now_next;
            run_reg       <= run_next;
            slice_reg     <= slice_next;
            dp_reg        <= dp_next;
            out_valid_reg <= out_valid_next;
            if (level_cap_we)
            begin
                cap_reg <= level_cap_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            svc_reg  <= req.work_units;
        end
        out_idx_reg   <= out_idx_next;
        out_idle_reg  <= out_idle_next;
        out_fin_reg   <= out_fin_next;
        out_ftime_reg <= out_ftime_next;
        out_turn_reg  <= out_turn_next;
        out_rej_reg   <= out_rej_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        run_next       = run_reg;
        slice_next     = slice_reg;
        dp_next        = dp_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_idx_next   = out_idx_reg;
        out_idle_next  = out_idle_reg;
        out_fin_next   = out_fin_reg;
        out_ftime_next = out_ftime_reg;
        out_turn_next  = out_turn_reg;
        out_rej_next   = out_rej_reg;
        wr             = '0;

        unique case (state_reg)
            fqds_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next   = '0;
                    state_next = fqds_pkg::ST_SCAN;
                end
            end
            fqds_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + fqds_pkg::HOP_CNT_W'(1);
                if (cnt_reg == fqds_pkg::HOP_CNT_W'(fqds_pkg::NUM_HOPS - 1))
                begin
                    state_next = fqds_pkg::ST_DONE;
                end
            end
            fqds_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next     = fqds_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_idle_next  = 1'b0;
                    out_fin_next   = 1'b0;
                    out_ftime_next = '0;
                    out_turn_next  = '0;
                    out_rej_next   = 1'b0;
                    if (func_reg == fqds_pkg::FUNC_ARRIVE)
                    begin
                        if (scan.free_found)
                        begin
                            wr.new_we    = 1'b1;
                            wr.new_idx   = scan.free_idx;
                            wr.new_rem   = svc_reg;
                            wr.new_arr   = now_reg;
                            out_idx_next = fqds_pkg::OUT_IDX_W'(scan.free_idx);
                        end
                        else
                        begin
                            out_rej_next = 1'b1;
                        end
                    end
                    else
                    begin
                        dp_next    = 1'b0;
                        now_next   = fin_t;
                        wr.lvl_we  = demote_apply;
                        wr.lvl_idx = run_reg;
                        wr.lvl_val = dem_lvl;
                        if (!resume && !scan.best_found)
                        begin
                            slice_next    = '0;
                            out_idle_next = 1'b1;
                        end
                        else
                        begin
                            run_next     = pick;
                            out_idx_next = fqds_pkg::OUT_IDX_W'(pick);
                            wr.upd_we    = 1'b1;
                            wr.upd_idx   = pick;
                            wr.upd_rem   = rem_dec;
                            if (rem_dec == '0)
                            begin
                                wr.upd_valid   = 1'b0;
                                slice_next     = '0;
                                out_fin_next   = 1'b1;
                                out_ftime_next = fqds_pkg::OUT_TIME_W'(fin_t);
                                out_turn_next  = fqds_pkg::OUT_TIME_W'(fin_t - pick_arr);
                            end
                            else
                            begin
                                wr.upd_valid = 1'b1;
                                slice_next   = slice_dec;
                                dp_next      = (slice_dec == '0);
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = fqds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/feedback_quantum_doubling_scheduler_unit.sv
// top level of the feedback scheduler: row of slot cells, hop registers, sequencer
// depends on fqds_pkg, fqds_if, fqds_cell and fqds_ctrl
//
// req carries items: func 0 registers a new process with its work_units,
// func 1 advances time by one unit. rsp returns exactly one item per request:
// the slot given on arrival (or rejected when all slots are taken), or the
// slot run on a tick with idle, finished, finish_time and turnaround.
// level_cap_we/level_cap_wdata set the highest feedback level; write it only
// while no request is in flight.
// Each request passes from acceptance through ST_SCAN and ST_DONE to the
// result register: the slot cells form a chain that is registered every
// four cells, and the lowest free slot and the lowest level/index are
// settled once the token has crossed every hop register. The sequencer
// returns to idle when it writes the result, and only then takes a new
// request; it takes none while one is still in flight.
// req.ready is high while the sequencer is idle, also while an earlier
// result still waits on rsp.
// If rsp stalls, the finished decision waits until the result register is
// free; nothing is lost. Reset empties all slots, clears time and the
// running slice, and sets the level cap to 7.
module feedback_quantum_doubling_scheduler_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    fqds_req_if.sink                      req,
    fqds_rsp_if.source                    rsp,
    input  logic                          level_cap_we,
    input  logic [fqds_pkg::LVL_W-1:0]    level_cap_wdata
);

    fqds_pkg::sched_t     sched;
    fqds_pkg::cell_wr_t   wr;
    fqds_pkg::scan_t      link [fqds_pkg::MAX_PROCS+1];
    fqds_pkg::scan_t      cell_in [fqds_pkg::MAX_PROCS];
    fqds_pkg::scan_t      hop_reg [fqds_pkg::NUM_HOPS];

    assign link[0] = '0;

    genvar i;
    generate
        for (i = 0; i < fqds_pkg::MAX_PROCS; i++)
        begin : g_cell
            if (i % fqds_pkg::CELLS_PER_HOP == 0 && i != 0)
            begin : g_from_hop
                assign cell_in[i] = hop_reg[i / fqds_pkg::CELLS_PER_HOP - 1];
            end
            else
            begin : g_from_link
                assign cell_in[i] = link[i];
            end

            fqds_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (fqds_pkg::IDX_W'(i)),
                .sched    (sched),
                .wr       (wr),
                .scan_in  (cell_in[i]),
                .scan_out (link[i+1])
            );

            if (i % fqds_pkg::CELLS_PER_HOP == fqds_pkg::CELLS_PER_HOP - 1 ||
                i == fqds_pkg::MAX_PROCS - 1)
            begin : g_hop
                always_ff @(posedge clk)
                begin
                    hop_reg[i / fqds_pkg::CELLS_PER_HOP] <= link[i+1];
                end
            end
        end
    endgenerate

    fqds_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .level_cap_we    (level_cap_we),
        .level_cap_wdata (level_cap_wdata),
        .scan            (hop_reg[fqds_pkg::NUM_HOPS-1]),
        .sched           (sched),
        .wr              (wr)
    );

endmodule

>>> src/fqds_checker.sv
// port-level checks on the scheduler result channel, bound to the top level
// depends on assert_macros.svh and fqds_pkg
`include "assert_macros.svh"

module fqds_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [fqds_pkg::OUT_IDX_W-1:0]    rsp_proc_index,
    input  logic                              rsp_idle,
    input  logic                              rsp_finished,
    input  logic [fqds_pkg::OUT_TIME_W-1:0]   rsp_finish_time,
    input  logic                              rsp_rejected
);

    `FQDS_ASSERT_ALWAYS(a_no_item_in_reset, clk, !rst_n |=> !rsp_valid, "result during reset")
    `FQDS_ASSERT(a_valid_holds, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")
    `FQDS_ASSERT(a_one_outcome, clk, rst_n, rsp_valid |-> $onehot0({rsp_idle, rsp_finished, rsp_rejected}), "conflicting outcome flags")
    `FQDS_ASSERT(a_idle_clean, clk, rst_n, rsp_valid && (rsp_idle || rsp_rejected) |-> rsp_proc_index == '0, "slot shown on idle or reject")
    `FQDS_ASSERT(a_ftime_only_fin, clk, rst_n, rsp_valid && !rsp_finished |-> rsp_finish_time == '0, "finish time without finish")

endmodule

bind feedback_quantum_doubling_scheduler_unit fqds_checker u_fqds_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_proc_index  (rsp.proc_index),
    .rsp_idle        (rsp.idle),
    .rsp_finished    (rsp.finished),
    .rsp_finish_time (rsp.finish_time),
    .rsp_rejected    (rsp.rejected)
);
